FILE: rtl/wcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_pkg
// shared types and constants of the washer cycle sequencer
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TURN_SECONDS  = 3'd0,
        CFG_FILL_TIMEOUT  = 3'd1,
        CFG_PAUSE_SECONDS = 3'd2,
        CFG_WASH_CYCLES   = 3'd3,
        CFG_DRAIN_FIRST   = 3'd4,
        CFG_DRAIN_EXTRA   = 3'd5,
        CFG_SPIN_MINUTES  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_FILL  = 3'd1,
        ST_WASH  = 3'd2,
        ST_DRAIN = 3'd3,
        ST_SPIN  = 3'd4
    } t_stage;

    typedef enum logic [1:0] {
        PH_LEFT    = 2'd0,
        PH_PAUSE_L = 2'd1,
        PH_RIGHT   = 2'd2,
        PH_PAUSE_R = 2'd3
    } t_phase;

    localparam int A_FILL  = 0;
    localparam int A_DRAIN = 1;
    localparam int A_LEFT  = 2;
    localparam int A_RIGHT = 3;
    localparam int A_SPIN  = 4;
    localparam int A_DONE  = 5;
    localparam int A_HEAT  = 6;
    localparam int ACT_W   = 7;

    localparam logic signed [7:0] HEAT_LIMIT  = 8'sd30;
    localparam logic [5:0]        SEC_PER_MIN = 6'd60;
    localparam logic [7:0]        COUNT_MAX   = 8'd255;

    typedef struct packed {
        logic [7:0] turn_seconds;
        logic [7:0] fill_timeout_minutes;
        logic [7:0] pause_seconds;
        logic [7:0] wash_cycles;
        logic [7:0] drain_cycles_first;
        logic [7:0] drain_cycles_extra;
        logic [7:0] final_spin_minutes;
    } t_cfg;

    typedef struct packed {
        logic              level_low;
        logic              level_high;
        logic              start_button;
        logic              alarm_clear;
        logic signed [7:0] water_temp;
    } t_item;

    typedef struct packed {
        logic       fill_valve;
        logic       drain_closed;
        logic       turn_left;
        logic       turn_right;
        logic       spin_motor;
        logic       done_lamp;
        logic       alarm_lamp;
        logic       heater_on;
        logic [2:0] stage;
    } t_result;

endpackage

FILE: rtl/wcs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_in_if
// tick word channel: level switches, buttons and water temperature
// ----------------------------------------------------------------------------
interface wcs_in_if;
    logic              valid;
    logic              ready;
    logic              level_low;
    logic              level_high;
    logic              start_button;
    logic              alarm_clear;
    logic signed [7:0] water_temp;

    modport source (
        output valid, level_low, level_high, start_button, alarm_clear, water_temp,
        input  ready
    );
    modport sink (
        input  valid, level_low, level_high, start_button, alarm_clear, water_temp,
        output ready
    );
endinterface

FILE: rtl/wcs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_out_if
// result word channel: actuator drives, lamps and stage
// ----------------------------------------------------------------------------
interface wcs_out_if;
    logic       valid;
    logic       ready;
    logic       fill_valve;
    logic       drain_closed;
    logic       turn_left;
    logic       turn_right;
    logic       spin_motor;
    logic       done_lamp;
    logic       alarm_lamp;
    logic       heater_on;
    logic [2:0] stage;

    modport source (
        output valid, fill_valve, drain_closed, turn_left, turn_right, spin_motor,
               done_lamp, alarm_lamp, heater_on, stage,
        input  ready
    );
    modport sink (
        input  valid, fill_valve, drain_closed, turn_left, turn_right, spin_motor,
               done_lamp, alarm_lamp, heater_on, stage,
        output ready
    );
endinterface

FILE: rtl/wcs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface wcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/washer_cycle_sequencer_unit.sv
`timescale 1ns / 1ps
// path: an accepted tick word waits in the input register, then steps into the result register
// throughput: one tick word per cycle while the result port is not stalled; the sequencer
//   step is combinational logic between the input register and the result register
// backpressure: a stalled result word holds one tick word in the input register
//   and then stalls the input; reset: synchronous active low; idle stage,
//   power-up check armed, all drives off, configuration at its default values
// ----------------------------------------------------------------------------
// washer_cycle_sequencer_unit
// wash program sequencer stepped by one-second tick words
// ----------------------------------------------------------------------------
module washer_cycle_sequencer_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    wcs_in_if.sink   i_in,
    wcs_cfg_if.sink  i_cfg,
    wcs_out_if.source o_out
);
    import wcs_pkg::*;

    t_cfg    cfg;
    t_result result;
    logic    step;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;

    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.level_low    <= i_in.level_low;
            r_item.level_high   <= i_in.level_high;
            r_item.start_button <= i_in.start_button;
            r_item.alarm_clear  <= i_in.alarm_clear;
            r_item.water_temp   <= i_in.water_temp;
        end
    end

    wcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    wcs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.fill_valve   = r_out.fill_valve;
    assign o_out.drain_closed = r_out.drain_closed;
    assign o_out.turn_left    = r_out.turn_left;
    assign o_out.turn_right   = r_out.turn_right;
    assign o_out.spin_motor   = r_out.spin_motor;
    assign o_out.done_lamp    = r_out.done_lamp;
    assign o_out.alarm_lamp   = r_out.alarm_lamp;
    assign o_out.heater_on    = r_out.heater_on;
    assign o_out.stage        = r_out.stage;

    a_spin_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.spin_motor == (r_out.stage == ST_SPIN)))
        else $error("spin drive disagrees with stage");

    a_fill_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fill_valve) |->
            (r_out.stage == ST_FILL || r_out.stage == ST_WASH))
        else $error("fill valve open outside fill or wash");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_out.ready && !r_in_valid) |=> !r_out_valid)
        else $error("result word repeated");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_item)))
        else $error("pending tick word lost");

endmodule

FILE: rtl/wcs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_cfg_regs
// timing and count registers written over the configuration channel
// ----------------------------------------------------------------------------
module wcs_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wcs_cfg_if.sink       i_cfg,
    output wcs_pkg::t_cfg o_cfg
);
    import wcs_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_seconds         <= 8'd1;
            r_cfg.fill_timeout_minutes <= 8'd1;
            r_cfg.pause_seconds        <= 8'd2;
            r_cfg.wash_cycles          <= 8'd10;
            r_cfg.drain_cycles_first   <= 8'd2;
            r_cfg.drain_cycles_extra   <= 8'd2;
            r_cfg.final_spin_minutes   <= 8'd5;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TURN_SECONDS:  r_cfg.turn_seconds         <= i_cfg.data;
                CFG_FILL_TIMEOUT:  r_cfg.fill_timeout_minutes <= i_cfg.data;
                CFG_PAUSE_SECONDS: r_cfg.pause_seconds        <= i_cfg.data;
                CFG_WASH_CYCLES:   r_cfg.wash_cycles          <= i_cfg.data;
                CFG_DRAIN_FIRST:   r_cfg.drain_cycles_first   <= i_cfg.data;
                CFG_DRAIN_EXTRA:   r_cfg.drain_cycles_extra   <= i_cfg.data;
                CFG_SPIN_MINUTES:  r_cfg.final_spin_minutes   <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/wcs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_core
// sequencer state and the next-state logic for one tick word
// ----------------------------------------------------------------------------
module wcs_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  wcs_pkg::t_item   i_item,
    input  wcs_pkg::t_cfg    i_cfg,
    output wcs_pkg::t_result o_result
);
    import wcs_pkg::*;

    t_stage           r_stage,   n_stage;
    t_phase           r_phase,   n_phase;
    logic [5:0]       r_sec,     n_sec;
    logic [7:0]       r_min,     n_min;
    logic [7:0]       r_cyc,     n_cyc;
    logic             r_tcp,     n_tcp;
    logic             r_alarm,   n_alarm;
    logic             r_pup,     n_pup;
    logic [ACT_W-1:0] r_act,     n_act;
    logic             go;
    logic             turns_on;
    logic [8:0]       drain_sum;
    logic [7:0]       drain_target;
    logic [5:0]       sec_inc;

    assign drain_sum    = {1'b0, i_cfg.drain_cycles_first} + {1'b0, i_cfg.drain_cycles_extra};
    assign drain_target = drain_sum[8] ? COUNT_MAX : drain_sum[7:0];

    always_comb begin
        n_stage  = r_stage;
        n_phase  = r_phase;
        n_sec    = r_sec;
        n_min    = r_min;
        n_cyc    = r_cyc;
        n_tcp    = r_tcp;
        n_alarm  = r_alarm;
        n_pup    = r_pup;
        n_act    = r_act;
        go       = 1'b1;
        turns_on = 1'b0;
        sec_inc  = '0;

        // alarm latch
        if (n_alarm) begin
            if (!i_item.alarm_clear) begin
                go = 1'b0;
            end else begin
                n_alarm = 1'b0;
                n_sec   = '0;
                n_min   = '0;
            end
        end

        // power-up level check
        if (go && n_pup) begin
            if (i_item.level_low || i_item.level_high) begin
                n_alarm = 1'b1;
            end else begin
                n_pup         = 1'b0;
                n_act[A_DONE] = 1'b1;
            end
            go = 1'b0;
        end

        if (go && n_stage == ST_IDLE) begin
            if (i_item.start_button) begin
                n_stage = ST_FILL;
            end else begin
                n_act[A_DONE] = 1'b1;
                go            = 1'b0;
            end
        end

        if (go) begin
            case (n_stage)
                ST_FILL: begin
                    n_act[A_DONE]  = 1'b0;
                    n_act[A_DRAIN] = 1'b1;
                    if (i_item.level_high) begin
                        n_act[A_FILL] = 1'b0;
                        n_stage       = ST_WASH;
                        n_phase       = PH_LEFT;
                        n_tcp         = 1'b1;
                    end else if (n_min >= i_cfg.fill_timeout_minutes) begin
                        n_act[A_FILL] = 1'b0;
                        n_alarm       = 1'b1;
                    end else if (n_sec != '0) begin
                        n_act[A_FILL] = 1'b1;
                    end
                end
                ST_WASH: begin
                    n_act[A_FILL] = !i_item.level_high;
                    turns_on      = 1'b1;
                end
                ST_DRAIN: begin
                    if (n_sec != '0) begin
                        n_act[A_DRAIN] = 1'b0;
                    end
                    turns_on = 1'b1;
                end
                ST_SPIN: begin
                    n_act[A_SPIN] = 1'b1;
                    if (n_min >= i_cfg.final_spin_minutes) begin
                        n_act[A_SPIN] = 1'b0;
                        n_tcp         = 1'b1;
                        n_stage       = ST_IDLE;
                    end
                end
                default: n_stage = ST_IDLE;
            endcase

            // drum turn and pause phases
            if (turns_on) begin
                case (n_phase)
                    PH_LEFT: begin
                        if ({2'b00, n_sec} >= i_cfg.turn_seconds) begin
                            n_phase = PH_PAUSE_L;
                            n_sec   = '0;
                            n_min   = '0;
                        end else begin
                            n_act[A_LEFT] = 1'b1;
                        end
                    end
                    PH_PAUSE_L: begin
                        if ({2'b00, n_sec} >= i_cfg.pause_seconds) begin
                            n_phase = PH_RIGHT;
                            n_sec   = '0;
                            n_min   = '0;
                        end else begin
                            n_act[A_LEFT] = 1'b0;
                        end
                    end
                    PH_RIGHT: begin
                        if ({2'b00, n_sec} >= i_cfg.turn_seconds) begin
                            n_phase = PH_PAUSE_R;
                            n_sec   = '0;
                            n_min   = '0;
                        end else begin
                            n_act[A_RIGHT] = 1'b1;
                        end
                    end
                    default: begin
                        if ({2'b00, n_sec} >= i_cfg.pause_seconds) begin
                            n_phase = PH_LEFT;
                            n_sec   = '0;
                            n_min   = '0;
                            if (n_cyc != COUNT_MAX) begin
                                n_cyc = n_cyc + 8'd1;
                            end
                        end else begin
                            n_act[A_RIGHT] = 1'b0;
                        end
                    end
                endcase
            end

            if (turns_on && n_stage == ST_WASH && n_cyc >= i_cfg.wash_cycles) begin
                n_cyc         = '0;
                n_act[A_FILL] = 1'b0;
                n_stage       = ST_DRAIN;
            end else if (turns_on && n_stage == ST_DRAIN) begin
                if (n_cyc < i_cfg.drain_cycles_first && !i_item.level_low) begin
                    n_cyc = i_cfg.drain_cycles_first;
                end else if (n_cyc == i_cfg.drain_cycles_first && i_item.level_low) begin
                    n_cyc   = '0;
                    n_alarm = 1'b1;
                end else if (n_cyc >= drain_target) begin
                    n_cyc          = '0;
                    n_sec          = '0;
                    n_min          = '0;
                    n_act[A_DONE]  = 1'b0;
                    n_act[A_RIGHT] = 1'b0;
                    n_act[A_SPIN]  = 1'b1;
                    n_stage        = ST_SPIN;
                end
            end

            // heater and time advance while running
            if (n_stage != ST_IDLE) begin
                n_act[A_HEAT] = (i_item.water_temp < HEAT_LIMIT);
                if (n_tcp) begin
                    n_sec = '0;
                    n_min = '0;
                    n_tcp = 1'b0;
                end else begin
                    sec_inc = n_sec + 6'd1;
                    if (sec_inc >= SEC_PER_MIN) begin
                        n_sec = '0;
                        if (n_min != COUNT_MAX) begin
                            n_min = n_min + 8'd1;
                        end
                    end else begin
                        n_sec = sec_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
            r_phase <= PH_LEFT;
            r_sec   <= '0;
            r_min   <= '0;
            r_cyc   <= '0;
            r_tcp   <= 1'b0;
            r_alarm <= 1'b0;
            r_pup   <= 1'b1;
            r_act   <= '0;
        end else if (i_step) begin
            r_stage <= n_stage;
            r_phase <= n_phase;
            r_sec   <= n_sec;
            r_min   <= n_min;
            r_cyc   <= n_cyc;
            r_tcp   <= n_tcp;
            r_alarm <= n_alarm;
            r_pup   <= n_pup;
            r_act   <= n_act;
        end
    end

    assign o_result.fill_valve   = n_act[A_FILL];
    assign o_result.drain_closed = n_act[A_DRAIN];
    assign o_result.turn_left    = n_act[A_LEFT];
    assign o_result.turn_right   = n_act[A_RIGHT];
    assign o_result.spin_motor   = n_act[A_SPIN];
    assign o_result.done_lamp    = n_act[A_DONE];
    assign o_result.alarm_lamp   = n_alarm;
    assign o_result.heater_on    = n_act[A_HEAT];
    assign o_result.stage        = n_stage;

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec < SEC_PER_MIN)
        else $error("second count out of range");

    a_alarm_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_alarm && !i_item.alarm_clear) |=>
            $stable(r_stage) && $stable(r_act) && r_alarm)
        else $error("state moved while alarm latched");

    a_pup_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pup |-> (r_stage == ST_IDLE))
        else $error("program running before power-up check");

endmodule
